### hdl/mlb_pkg.sv
// Shared types, register indexes and helper functions of the metadynamics
// bias-force block. No dependencies; all other files but mlb_ram use it.
`default_nettype none

package mlb_pkg;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_DIST = 2'd1;
  localparam logic [1:0] MODE_RELZ = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_CMIN   = 3'd3;
  localparam logic [2:0] REG_CMAX   = 3'd4;
  localparam logic [2:0] REG_STEP   = 3'd5;
  localparam logic [2:0] REG_BFORCE = 3'd6;
  localparam logic [2:0] REG_PERIOD = 3'd7;

  localparam logic [1:0] KIND_OFF  = 2'd0;
  localparam logic [1:0] KIND_DIST = 2'd1;
  localparam logic [1:0] KIND_RELZ = 2'd2;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [30:0]        height;
    logic [30:0]        width;
    logic signed [31:0] cmin;
    logic signed [31:0] cmax;
    logic [30:0]        bstep;
    logic [30:0]        bforce;
    logic [15:0]        period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [31:0]        stepn;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
    logic [63:0] rem;
  } arith_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Magnitude of a signed 32-bit value, zero-extended to 64 bits.
  function automatic logic [63:0] mag32(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    if (e < 0) begin
      e = -e;
    end
    return {31'b0, e};
  endfunction

endpackage

`default_nettype wire

### hdl/metadynamics_lucy_bias_update.sv
// One transaction is processed at a time; all work runs on one bit-serial unit
// (divides, multiplies, a square root). With the mode off no arithmetic is done. On
// update steps every bin is visited, with more arithmetic for each bin inside the
// kernel width. A two-entry queue buffers inputs while a transaction is in work.
// Reset: synchronous, active low; clearing every table bin then holds in_tready low.
`default_nettype none

module metadynamics_lucy_bias_update #(
  parameter int BINS = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // disp_x, disp_y, disp_z, step_number (lowest bit up)
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // force_x, force_y, force_z, coord_value (lowest bit up)
  output logic [127:0]      out_tdata,
  // status
  output logic              out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  mlb_pkg::cfg_t  cfg_r, cfg_nxt;
  mlb_pkg::item_t head;
  logic           head_valid;
  logic           pop;
  logic           clearing;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        mlb_pkg::REG_MODE:   cfg_nxt.mode   = cfg_wdata[1:0];
        mlb_pkg::REG_HEIGHT: cfg_nxt.height = cfg_wdata[30:0];
        mlb_pkg::REG_WIDTH:  cfg_nxt.width  = cfg_wdata[30:0];
        mlb_pkg::REG_CMIN:   cfg_nxt.cmin   = cfg_wdata;
        mlb_pkg::REG_CMAX:   cfg_nxt.cmax   = cfg_wdata;
        mlb_pkg::REG_STEP:   cfg_nxt.bstep  = cfg_wdata[30:0];
        mlb_pkg::REG_BFORCE: cfg_nxt.bforce = cfg_wdata[30:0];
        mlb_pkg::REG_PERIOD: cfg_nxt.period = cfg_wdata[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= mlb_pkg::MODE_OFF;
      cfg_r.height <= 31'd66;
      cfg_r.width  <= 31'd32768;
      cfg_r.cmin   <= 32'sd65536;
      cfg_r.cmax   <= 32'sd0;
      cfg_r.bstep  <= 31'd65536;
      cfg_r.bforce <= 31'd655360;
      cfg_r.period <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mlb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .mode       (cfg_r.mode),
    .hold       (clearing),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  mlb_back #(
    .BINS (BINS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### hdl/mlb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/mlb_arith.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide
// and digit-by-digit square root, one step per cycle. Uses mlb_pkg.
`default_nettype none

module mlb_arith (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mlb_pkg::arith_req_t req,
  output mlb_pkg::arith_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [65:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [65:0] shifted;
  logic [65:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    shifted  = '0;
    trial    = '0;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        a_nxt    = req.a;
        b_nxt    = req.b;
        acc_nxt  = '0;
        q_nxt    = '0;
        cnt_nxt  = (req.op == mlb_pkg::OP_SQRT) ? 7'd32 : 7'd64;
      end
    end else begin
      case (op_r)
        mlb_pkg::OP_MUL: begin
          if (b_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            if (b_r[0]) begin
              acc_nxt = acc_r + {2'b0, a_r};
            end
            a_nxt = {a_r[62:0], 1'b0};
            b_nxt = {1'b0, b_r[63:1]};
          end
        end
        mlb_pkg::OP_DIV: begin
          // The dividend register fills with quotient bits from the bottom.
          shifted = {1'b0, acc_r[63:0], a_r[63]};
          trial   = {2'b0, b_r};
          if (shifted >= trial) begin
            acc_nxt = shifted - trial;
            a_nxt   = {a_r[62:0], 1'b1};
          end else begin
            acc_nxt = shifted;
            a_nxt   = {a_r[62:0], 1'b0};
          end
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        mlb_pkg::OP_SQRT: begin
          shifted = {acc_r[63:0], a_r[63:62]};
          trial   = {q_r, 2'b01};
          if (shifted >= trial) begin
            acc_nxt = shifted - trial;
            q_nxt   = {q_r[62:0], 1'b1};
          end else begin
            acc_nxt = shifted;
            q_nxt   = {q_r[62:0], 1'b0};
          end
          a_nxt   = {a_r[61:0], 2'b00};
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    rsp.rem  = acc_r[63:0];
    case (op_r)
      mlb_pkg::OP_DIV:  rsp.res = a_r;
      mlb_pkg::OP_SQRT: rsp.res = q_r;
      default:          rsp.res = acc_r[63:0];
    endcase
  end

endmodule

`default_nettype wire

### hdl/mlb_front.sv
// Input side: accepts displacement transactions, tags them with the active
// coordinate kind and holds them in a two-entry queue. Uses mlb_pkg.
`default_nettype none

module mlb_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [127:0]   in_tdata,
  input  wire logic [1:0]     mode,
  input  wire logic           hold,
  output mlb_pkg::item_t      head,
  output logic                head_valid,
  input  wire logic           pop
);

  mlb_pkg::item_t slot_r [2];
  mlb_pkg::item_t incoming;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           take;

  always_comb begin
    case (mode)
      mlb_pkg::MODE_DIST: incoming.kind = mlb_pkg::KIND_DIST;
      mlb_pkg::MODE_RELZ: incoming.kind = mlb_pkg::KIND_RELZ;
      default:            incoming.kind = mlb_pkg::KIND_OFF;
    endcase
    incoming.dx    = in_tdata[31:0];
    incoming.dy    = in_tdata[63:32];
    incoming.dz    = in_tdata[95:64];
    incoming.stepn = in_tdata[127:96];
  end

  assign in_tready  = (count_r != 2'd2) && !hold;
  assign push       = in_tvalid && in_tready;
  assign head_valid = (count_r != 2'd0);
  assign take       = pop && head_valid;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

`default_nettype wire

### hdl/mlb_back.sv
// Execution side: sequencer that forms the coordinate, updates the bias-force
// table, picks the force factor and projects it. Uses mlb_pkg, mlb_arith, mlb_ram.
`default_nettype none

module mlb_back #(
  parameter int BINS = 128
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mlb_pkg::cfg_t  cfg,
  input  wire mlb_pkg::item_t head,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                clearing,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [127:0]        out_tdata,
  output logic                out_tuser
);

  localparam int AW = $clog2(BINS);
  localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_LOAD  = 5'd2;
  localparam logic [4:0] ST_SQ    = 5'd3;
  localparam logic [4:0] ST_SQRT  = 5'd4;
  localparam logic [4:0] ST_MODW  = 5'd5;
  localparam logic [4:0] ST_BIN   = 5'd6;
  localparam logic [4:0] ST_U     = 5'd7;
  localparam logic [4:0] ST_V     = 5'd8;
  localparam logic [4:0] ST_HV    = 5'd9;
  localparam logic [4:0] ST_MAG   = 5'd10;
  localparam logic [4:0] ST_BNEXT = 5'd11;
  localparam logic [4:0] ST_FAC   = 5'd12;
  localparam logic [4:0] ST_RAMP  = 5'd13;
  localparam logic [4:0] ST_RDIV  = 5'd14;
  localparam logic [4:0] ST_IDX   = 5'd15;
  localparam logic [4:0] ST_TRD   = 5'd16;
  localparam logic [4:0] ST_TGET  = 5'd17;
  localparam logic [4:0] ST_FORCE = 5'd18;
  localparam logic [4:0] ST_FM    = 5'd19;
  localparam logic [4:0] ST_FD    = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;

  logic [4:0]         state_r, state_nxt;
  logic [AW-1:0]      bin_r, bin_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic signed [31:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [31:0]        stepn_r, stepn_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic signed [47:0] c_r, c_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] factor_r, factor_nxt;
  logic signed [31:0] fx_r, fx_nxt, fy_r, fy_nxt, fz_r, fz_nxt;
  logic               status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [127:0]       out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  mlb_pkg::arith_req_t req;
  mlb_pkg::arith_rsp_t rsp;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;

  logic [15:0]        period_eff;
  logic [30:0]        step_eff;
  logic signed [31:0] axis_d;
  logic signed [31:0] next_d;
  logic signed [47:0] diff;
  logic [47:0]        dabs;
  logic [63:0]        sq_sum;
  logic signed [32:0] lo_m_x;
  logic signed [32:0] x_m_hi;
  logic signed [32:0] x_m_lo;
  logic signed [65:0] q_signed;
  logic signed [65:0] tbl_new;

  mlb_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  mlb_ram #(
    .WIDTH (32),
    .DEPTH (BINS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign period_eff = (cfg.period == '0) ? 16'd1 : cfg.period;
  assign step_eff   = (cfg.bstep == '0) ? 31'd1 : cfg.bstep;
  assign ram_raddr  = (state_r == ST_TRD || state_r == ST_TGET) ? idx_r : bin_r;
  assign clearing   = (state_r == ST_CLEAR);

  always_comb begin
    case (axis_r)
      2'd0:    axis_d = dx_r;
      2'd1:    axis_d = dy_r;
      default: axis_d = dz_r;
    endcase
    next_d = (axis_r == 2'd0) ? dy_r : dz_r;
  end

  assign diff     = c_r - 48'(x_r);
  assign dabs     = (diff < 0) ? 48'(-diff) : 48'(diff);
  assign sq_sum   = sum_r + rsp.res;
  assign lo_m_x   = 33'(cfg.cmin) - 33'(x_r);
  assign x_m_hi   = 33'(x_r) - 33'(cfg.cmax);
  assign x_m_lo   = 33'(x_r) - 33'(cfg.cmin);
  assign q_signed = $signed({2'b00, rsp.res});
  assign tbl_new  = neg_r ? (66'($signed(ram_rdata)) + q_signed)
                          : (66'($signed(ram_rdata)) - q_signed);

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    idx_nxt       = idx_r;
    axis_nxt      = axis_r;
    kind_nxt      = kind_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    stepn_nxt     = stepn_r;
    x_nxt         = x_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    c_nxt         = c_r;
    neg_nxt       = neg_r;
    factor_nxt    = factor_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    fz_nxt        = fz_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pop           = 1'b0;
    req.start     = 1'b0;
    req.op        = mlb_pkg::OP_MUL;
    req.a         = '0;
    req.b         = '0;
    ram_we        = 1'b0;
    ram_waddr     = bin_r;
    ram_wdata     = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (bin_r == LAST_BIN) begin
          bin_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          bin_nxt = bin_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          kind_nxt  = head.kind;
          dx_nxt    = head.dx;
          dy_nxt    = head.dy;
          dz_nxt    = head.dz;
          stepn_nxt = head.stepn;
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        status_nxt = 1'b0;
        fx_nxt     = '0;
        fy_nxt     = '0;
        fz_nxt     = '0;
        case (kind_r)
          mlb_pkg::KIND_DIST: begin
            sum_nxt   = '0;
            axis_nxt  = 2'd0;
            req.start = 1'b1;
            req.op    = mlb_pkg::OP_MUL;
            req.a     = mlb_pkg::mag32(dx_r);
            req.b     = mlb_pkg::mag32(dx_r);
            state_nxt = ST_SQ;
          end
          mlb_pkg::KIND_RELZ: begin
            x_nxt     = mlb_pkg::sat32(-(66'(dz_r)));
            req.start = 1'b1;
            req.op    = mlb_pkg::OP_DIV;
            req.a     = {32'b0, stepn_r};
            req.b     = {48'b0, period_eff};
            state_nxt = ST_MODW;
          end
          default: begin
            x_nxt     = '0;
            state_nxt = ST_OUT;
          end
        endcase
      end

      ST_SQ: begin
        if (rsp.done) begin
          sum_nxt   = sq_sum;
          req.start = 1'b1;
          if (axis_r == 2'd2) begin
            req.op    = mlb_pkg::OP_SQRT;
            req.a     = sq_sum;
            state_nxt = ST_SQRT;
          end else begin
            axis_nxt = axis_r + 2'd1;
            req.op   = mlb_pkg::OP_MUL;
            req.a    = mlb_pkg::mag32(next_d);
            req.b    = mlb_pkg::mag32(next_d);
          end
        end
      end

      ST_SQRT: begin
        if (rsp.done) begin
          len_nxt   = rsp.res[31:0];
          x_nxt     = rsp.res[31] ? 32'sh7fffffff : $signed(rsp.res[31:0]);
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_DIV;
          req.a     = {32'b0, stepn_r};
          req.b     = {48'b0, period_eff};
          state_nxt = ST_MODW;
        end
      end

      ST_MODW: begin
        if (rsp.done) begin
          if (rsp.rem == '0) begin
            bin_nxt   = '0;
            c_nxt     = 48'(cfg.cmin);
            state_nxt = ST_BIN;
          end else begin
            state_nxt = ST_FAC;
          end
        end
      end

      ST_BIN: begin
        neg_nxt = (diff < 0);
        if (cfg.width == '0 || dabs > {17'b0, cfg.width}) begin
          state_nxt = ST_BNEXT;
        end else begin
          // Normalized distance u = d * 2^32 / w, at most 2^32.
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_DIV;
          req.a     = {dabs[31:0], 32'b0};
          req.b     = {33'b0, cfg.width};
          state_nxt = ST_U;
        end
      end

      ST_U: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_MUL;
          req.a     = rsp.res;
          req.b     = 64'h1_0000_0000 - rsp.res;
          state_nxt = ST_V;
        end
      end

      ST_V: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_MUL;
          req.a     = {33'b0, cfg.height};
          req.b     = {32'b0, rsp.res[63:32]};
          state_nxt = ST_HV;
        end
      end

      ST_HV: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_DIV;
          req.a     = {rsp.res[61:0], 2'b00} + {rsp.res[62:0], 1'b0};
          req.b     = {17'b0, cfg.width, 16'b0};
          state_nxt = ST_MAG;
        end
      end

      ST_MAG: begin
        if (rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = mlb_pkg::sat32(tbl_new);
          state_nxt = ST_BNEXT;
        end
      end

      ST_BNEXT: begin
        if (bin_r == LAST_BIN) begin
          state_nxt = ST_FAC;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          c_nxt     = c_r + 48'(step_eff);
          state_nxt = ST_BIN;
        end
      end

      ST_FAC: begin
        req.start = 1'b1;
        if ($signed(x_r) < $signed(cfg.cmin)) begin
          neg_nxt   = 1'b1;
          req.op    = mlb_pkg::OP_MUL;
          req.a     = {33'b0, cfg.bforce};
          req.b     = {31'b0, lo_m_x};
          state_nxt = ST_RAMP;
        end else if ($signed(x_r) > $signed(cfg.cmax)) begin
          neg_nxt   = 1'b0;
          req.op    = mlb_pkg::OP_MUL;
          req.a     = {33'b0, cfg.bforce};
          req.b     = {31'b0, x_m_hi};
          state_nxt = ST_RAMP;
        end else begin
          // Nearest bin, halves rounded up.
          req.op    = mlb_pkg::OP_DIV;
          req.a     = {30'b0, x_m_lo, 1'b0} + {33'b0, step_eff};
          req.b     = {32'b0, step_eff, 1'b0};
          state_nxt = ST_IDX;
        end
      end

      ST_RAMP: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_DIV;
          req.a     = rsp.res;
          req.b     = {33'b0, step_eff};
          state_nxt = ST_RDIV;
        end
      end

      ST_RDIV: begin
        if (rsp.done) begin
          factor_nxt = mlb_pkg::sat32(neg_r ? -q_signed : q_signed);
          state_nxt  = ST_FORCE;
        end
      end

      ST_IDX: begin
        if (rsp.done) begin
          idx_nxt   = (rsp.res > 64'(BINS - 1)) ? LAST_BIN : rsp.res[AW-1:0];
          state_nxt = ST_TRD;
        end
      end

      ST_TRD: begin
        state_nxt = ST_TGET;
      end

      ST_TGET: begin
        factor_nxt = $signed(ram_rdata);
        state_nxt  = ST_FORCE;
      end

      ST_FORCE: begin
        if (kind_r == mlb_pkg::KIND_RELZ) begin
          fz_nxt    = mlb_pkg::sat32(-(66'(factor_r)));
          state_nxt = ST_OUT;
        end else if (len_r == '0) begin
          status_nxt = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          axis_nxt  = 2'd0;
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_MUL;
          req.a     = mlb_pkg::mag32(factor_r);
          req.b     = mlb_pkg::mag32(dx_r);
          state_nxt = ST_FM;
        end
      end

      ST_FM: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = mlb_pkg::OP_DIV;
          req.a     = rsp.res;
          req.b     = {32'b0, len_r};
          state_nxt = ST_FD;
        end
      end

      ST_FD: begin
        if (rsp.done) begin
          // The force takes the sign of factor times displacement.
          if (factor_r[31] ^ axis_d[31]) begin
            factor_nxt = factor_r;
            case (axis_r)
              2'd0:    fx_nxt = mlb_pkg::sat32(-q_signed);
              2'd1:    fy_nxt = mlb_pkg::sat32(-q_signed);
              default: fz_nxt = mlb_pkg::sat32(-q_signed);
            endcase
          end else begin
            case (axis_r)
              2'd0:    fx_nxt = mlb_pkg::sat32(q_signed);
              2'd1:    fy_nxt = mlb_pkg::sat32(q_signed);
              default: fz_nxt = mlb_pkg::sat32(q_signed);
            endcase
          end
          if (axis_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            req.start = 1'b1;
            req.op    = mlb_pkg::OP_MUL;
            req.a     = mlb_pkg::mag32(factor_r);
            req.b     = mlb_pkg::mag32(next_d);
            state_nxt = ST_FM;
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {x_r, fz_r, fy_r, fx_r};
          out_user_nxt  = status_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bin_r       <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_r       <= bin_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    kind_r     <= kind_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dz_r       <= dz_nxt;
    stepn_r    <= stepn_nxt;
    x_r        <= x_nxt;
    len_r      <= len_nxt;
    sum_r      <= sum_nxt;
    c_r        <= c_nxt;
    neg_r      <= neg_nxt;
    factor_r   <= factor_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    fz_r       <= fz_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !rsp.busy)
    else $error("arithmetic unit started while busy");

  a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_MAG))
    else $error("table written outside clearing or update");

  a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[95:0] == '0))
    else $error("zero-length status with nonzero force");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_LOAD))
    else $error("queue popped outside idle");
`endif

endmodule

`default_nettype wire
